// ===== rtl/core/carpid_pkg.sv =====
// Shared types and constants of the cascaded angle/rate PID controller.
package carpid_pkg;

   // Field widths.
   localparam int DATA_W = 32;
   localparam int LIM_W  = 31;
   localparam int OPND_W = 33;
   localparam int PROD_W = 64;
   localparam int TERM_W = 48;
   localparam int ACC_W  = 51;
   localparam int ADDR_W = 5;

   // Register map, one 32-bit word per register.
   typedef enum logic [2:0] {
      REG_ANGLE_P = 3'd0,
      REG_ANGLE_I = 3'd1,
      REG_ANGLE_D = 3'd2,
      REG_RATE_P  = 3'd3,
      REG_RATE_I  = 3'd4,
      REG_RATE_D  = 3'd5,
      REG_LIMIT   = 3'd6
   } reg_index_type;

   // Register reset values.
   localparam logic [DATA_W-1:0] ANGLE_P_RST = 32'd589824;
   localparam logic [DATA_W-1:0] ANGLE_I_RST = 32'd1311;
   localparam logic [DATA_W-1:0] ANGLE_D_RST = 32'd22938;
   localparam logic [DATA_W-1:0] RATE_P_RST  = 32'd72090;
   localparam logic [DATA_W-1:0] RATE_I_RST  = 32'd0;
   localparam logic [DATA_W-1:0] RATE_D_RST  = 32'd0;
   localparam logic [LIM_W-1:0]  LIMIT_RST   = 31'd131072;

   // Current gain set as seen by the datapath.
   typedef struct packed {
      logic [DATA_W-1:0] angle_p;
      logic [DATA_W-1:0] angle_i;
      logic [DATA_W-1:0] angle_d;
      logic [DATA_W-1:0] rate_p;
      logic [DATA_W-1:0] rate_i;
      logic [DATA_W-1:0] rate_d;
      logic [LIM_W-1:0]  limit;
   } gains_type;

   // Operand pair routed to the shared multiplier.
   typedef enum logic [3:0] {
      MUL_AP_AE   = 4'd0,
      MUL_AE_RCP  = 4'd1,
      MUL_RE_RCP  = 4'd2,
      MUL_QAE_HZ  = 4'd3,
      MUL_QRE_HZ  = 4'd4,
      MUL_DIFF_HZ = 4'd5,
      MUL_RP_RE   = 4'd6,
      MUL_RD_DR   = 4'd7,
      MUL_AD_RATE = 4'd8,
      MUL_RI_RSUM = 4'd9,
      MUL_AI_ASUM = 4'd10
   } mul_sel_type;

   // Command word from the sequencer to the datapath.
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        ld_in;
      logic        wr_re;
      logic        wr_qae;
      logic        wr_qre;
      logic        fix_ae;
      logic        fix_re;
      logic        wr_dr;
      logic        upd_sums;
      logic        acc_clr;
      logic        acc_add;
      logic        upd_last;
      logic        wr_out;
   } cmd_type;

endpackage

// ===== rtl/core/carpid_req_if.sv =====
// Input channel: one control tick per beat.
interface carpid_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] target_angle;
   logic signed [31:0] measured_angle;
   logic signed [31:0] measured_rate;

   modport source (output valid, output target_angle, output measured_angle,
                   output measured_rate, input ready);
   modport sink   (input valid, input target_angle, input measured_angle,
                   input measured_rate, output ready);
endinterface

// ===== rtl/core/carpid_rsp_if.sv =====
// Result channel: one drive value per beat.
interface carpid_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive_value;

   modport source (output valid, output drive_value, input ready);
   modport sink   (input valid, input drive_value, output ready);
endinterface

// ===== rtl/core/cascaded_angle_rate_pid.sv =====
// Top level of the cascaded angle/rate PID controller for one axis.
//
//   Channel   Direction   Beat carries
//   req_ch    in          target_angle, measured_angle, measured_rate (Q16.16)
//   rsp_ch    out         drive_value (Q16.16, saturated)
//   APB       in/out      gains and integral limit, word registers 0 to 6
//
// A tick runs through the accept cycle plus 13 sequencer steps, set by the single
// shared 33x33 multiplier that forms eleven products one after another.
// Reset is synchronous: gains return to their defaults, both integrals and the
// previous rate error clear.
// The result waits in an output register; the next tick is accepted meanwhile and
// holds at its last step only while the previous result beat is still untaken.
module cascaded_angle_rate_pid #(
   parameter int LOOP_RATE_HZ = 200
) (
   input  logic                              clock,
   input  logic                              reset,
   carpid_req_if.sink                        req_ch,
   carpid_rsp_if.source                      rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [carpid_pkg::ADDR_W-1:0]     paddr,
   input  logic [carpid_pkg::DATA_W-1:0]     pwdata,
   output logic [carpid_pkg::DATA_W-1:0]     prdata,
   output logic                              pready
);

   carpid_pkg::gains_type gains;
   carpid_pkg::cmd_type   cmd;
   logic                  req_ready;
   logic                  rsp_valid;

   // Configuration registers.
   carpid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   // Step sequencer and handshakes.
   carpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // Arithmetic.
   carpid_dp #(
      .LOOP_RATE_HZ (LOOP_RATE_HZ)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .gains          (gains),
      .target_angle   (req_ch.target_angle),
      .measured_angle (req_ch.measured_angle),
      .measured_rate  (req_ch.measured_rate),
      .drive_value    (rsp_ch.drive_value)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

// ===== rtl/core/carpid_csr.sv =====
// APB register file holding the gains and the integral limit.
module carpid_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [carpid_pkg::ADDR_W-1:0]     paddr,
   input  logic [carpid_pkg::DATA_W-1:0]     pwdata,
   output logic [carpid_pkg::DATA_W-1:0]     prdata,
   output logic                              pready,
   output carpid_pkg::gains_type             gains
);

   carpid_pkg::gains_type     gains_ff;
   carpid_pkg::gains_type     gains_in;
   carpid_pkg::reg_index_type idx;
   logic                      wr_en;

   assign pready = 1'b1;
   assign idx    = carpid_pkg::reg_index_type'(paddr[carpid_pkg::ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign gains  = gains_ff;

   // Register write decode; an address past the map is ignored.
   always_comb begin
      gains_in = gains_ff;
      if (wr_en) begin
         unique case (idx)
            carpid_pkg::REG_ANGLE_P: gains_in.angle_p = pwdata;
            carpid_pkg::REG_ANGLE_I: gains_in.angle_i = pwdata;
            carpid_pkg::REG_ANGLE_D: gains_in.angle_d = pwdata;
            carpid_pkg::REG_RATE_P:  gains_in.rate_p  = pwdata;
            carpid_pkg::REG_RATE_I:  gains_in.rate_i  = pwdata;
            carpid_pkg::REG_RATE_D:  gains_in.rate_d  = pwdata;
            carpid_pkg::REG_LIMIT:   gains_in.limit   = pwdata[carpid_pkg::LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.angle_p <= carpid_pkg::ANGLE_P_RST;
         gains_ff.angle_i <= carpid_pkg::ANGLE_I_RST;
         gains_ff.angle_d <= carpid_pkg::ANGLE_D_RST;
         gains_ff.rate_p  <= carpid_pkg::RATE_P_RST;
         gains_ff.rate_i  <= carpid_pkg::RATE_I_RST;
         gains_ff.rate_d  <= carpid_pkg::RATE_D_RST;
         gains_ff.limit   <= carpid_pkg::LIMIT_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (idx)
         carpid_pkg::REG_ANGLE_P: prdata = gains_ff.angle_p;
         carpid_pkg::REG_ANGLE_I: prdata = gains_ff.angle_i;
         carpid_pkg::REG_ANGLE_D: prdata = gains_ff.angle_d;
         carpid_pkg::REG_RATE_P:  prdata = gains_ff.rate_p;
         carpid_pkg::REG_RATE_I:  prdata = gains_ff.rate_i;
         carpid_pkg::REG_RATE_D:  prdata = gains_ff.rate_d;
         carpid_pkg::REG_LIMIT:   prdata = {1'b0, gains_ff.limit};
         default:                 prdata = '0;
      endcase
   end

endmodule

// ===== rtl/core/carpid_ctrl.sv =====
// Sequencer: steps one tick through the shared multiplier and drives the handshakes.
module carpid_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output carpid_pkg::cmd_type cmd
);

   typedef enum logic [13:0] {
      ST_IDLE = 14'b00000000000001,
      ST_M0   = 14'b00000000000010,
      ST_M1   = 14'b00000000000100,
      ST_M2   = 14'b00000000001000,
      ST_M3   = 14'b00000000010000,
      ST_M4   = 14'b00000000100000,
      ST_M5   = 14'b00000001000000,
      ST_M6   = 14'b00000010000000,
      ST_M7   = 14'b00000100000000,
      ST_M8   = 14'b00001000000000,
      ST_M9   = 14'b00010000000000,
      ST_M10  = 14'b00100000000000,
      ST_M11  = 14'b01000000000000,
      ST_M12  = 14'b10000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_busy;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // The result register is still holding a beat that has not been taken.
   assign out_busy  = rsp_valid_ff && !rsp_ready;

   // Step decode: steps M0 to M10 each launch one product; steps M1 to M11 retire the one before.
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = carpid_pkg::MUL_AP_AE;
      state_in     = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.ld_in = 1'b1;
               state_in  = ST_M0;
            end
         end
         ST_M0: begin
            cmd.mul_sel = carpid_pkg::MUL_AP_AE;
            state_in    = ST_M1;
         end
         ST_M1: begin
            cmd.wr_re   = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_AE_RCP;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.wr_qae  = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_AD_RATE;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.acc_clr = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_RE_RCP;
            state_in    = ST_M4;
         end
         ST_M4: begin
            cmd.wr_qre  = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_QAE_HZ;
            state_in    = ST_M5;
         end
         ST_M5: begin
            cmd.fix_ae  = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_QRE_HZ;
            state_in    = ST_M6;
         end
         ST_M6: begin
            cmd.fix_re  = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_DIFF_HZ;
            state_in    = ST_M7;
         end
         ST_M7: begin
            cmd.wr_dr    = 1'b1;
            cmd.upd_sums = 1'b1;
            cmd.mul_sel  = carpid_pkg::MUL_RP_RE;
            state_in     = ST_M8;
         end
         ST_M8: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_RD_DR;
            state_in    = ST_M9;
         end
         ST_M9: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_RI_RSUM;
            state_in    = ST_M10;
         end
         ST_M10: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = carpid_pkg::MUL_AI_ASUM;
            state_in    = ST_M11;
         end
         ST_M11: begin
            cmd.acc_add  = 1'b1;
            cmd.upd_last = 1'b1;
            state_in     = ST_M12;
         end
         ST_M12: begin
            // Hold here until the result register is free.
            if (!out_busy) begin
               cmd.wr_out = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid flag: set on load, cleared when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.wr_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_one_tick_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second tick accepted while one is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_out |-> !(rsp_valid && !rsp_ready))
      else $error("result register overwritten before its beat was taken");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_out |=> rsp_valid)
      else $error("result loaded but not presented");
`endif

endmodule

// ===== rtl/core/carpid_dp.sv =====
// Datapath: operand registers, one shared 33x33 multiplier, integrals and accumulator.
module carpid_dp #(
   parameter int LOOP_RATE_HZ = 200
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  carpid_pkg::cmd_type                   cmd,
   input  carpid_pkg::gains_type                 gains,
   input  logic signed [carpid_pkg::DATA_W-1:0]  target_angle,
   input  logic signed [carpid_pkg::DATA_W-1:0]  measured_angle,
   input  logic signed [carpid_pkg::DATA_W-1:0]  measured_rate,
   output logic signed [carpid_pkg::DATA_W-1:0]  drive_value
);

   // A loop rate below one acts as one.
   localparam int HzEff = (LOOP_RATE_HZ < 1) ? 1 : LOOP_RATE_HZ;
   // floor((2^32 - 1) / hz): x * HZ_RECIP >> 32 is x / hz or one below for x <= 2^31.
   localparam logic [31:0] HZ_RECIP = 32'(64'h0000_0000_FFFF_FFFF / 64'(HzEff));
   localparam logic [32:0] HZ_U       = 33'(HzEff);
   localparam logic [32:0] HZ_TWICE_U = 33'(2 * HzEff);

   function automatic logic signed [31:0] sat_to_32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < 64'shFFFF_FFFF_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] s,
                                                    input logic signed [32:0] q,
                                                    input logic [30:0] lim);
      logic signed [33:0] t;
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      logic signed [31:0] r;
      t  = {{2{s[31]}}, s} + {q[32], q};
      hi = {3'b000, lim};
      lo = -hi;
      if (t > hi) begin
         r = hi[31:0];
      end else if (t < lo) begin
         r = lo[31:0];
      end else begin
         r = t[31:0];
      end
      return r;
   endfunction

   // Working registers.
   logic signed [31:0] rate_ff, rate_in;
   logic signed [31:0] ae_ff, ae_in;
   logic        [31:0] abs_ae_ff, abs_ae_in;
   logic signed [31:0] re_ff, re_in;
   logic        [31:0] abs_re_ff, abs_re_in;
   logic signed [32:0] diff_ff, diff_in;
   logic        [31:0] q_ae_ff, q_ae_in;
   logic        [31:0] q_re_ff, q_re_in;
   logic signed [32:0] sq_ae_ff, sq_ae_in;
   logic signed [32:0] sq_re_ff, sq_re_in;
   logic signed [31:0] dr_ff, dr_in;
   logic signed [31:0] asum_ff, asum_in;
   logic signed [31:0] rsum_ff, rsum_in;
   logic signed [31:0] last_ff, last_in;
   logic signed [carpid_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [carpid_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [31:0] out_ff, out_in;

   // Multiplier operands and derived values.
   logic signed [carpid_pkg::OPND_W-1:0]   opa;
   logic signed [carpid_pkg::OPND_W-1:0]   opb;
   logic signed [2*carpid_pkg::OPND_W-1:0] full;
   logic signed [carpid_pkg::TERM_W-1:0]   term;
   logic signed [31:0]                     tr;
   logic        [32:0]                     rem_ae;
   logic        [32:0]                     rem_re;
   logic                                   up_ae;
   logic                                   up_re;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_sel)
         carpid_pkg::MUL_AP_AE: begin
            opa = {gains.angle_p[31], gains.angle_p};
            opb = {ae_ff[31], ae_ff};
         end
         carpid_pkg::MUL_AE_RCP: begin
            opa = {1'b0, abs_ae_ff};
            opb = {1'b0, HZ_RECIP};
         end
         carpid_pkg::MUL_RE_RCP: begin
            opa = {1'b0, abs_re_ff};
            opb = {1'b0, HZ_RECIP};
         end
         carpid_pkg::MUL_QAE_HZ: begin
            opa = {1'b0, q_ae_ff};
            opb = HZ_U;
         end
         carpid_pkg::MUL_QRE_HZ: begin
            opa = {1'b0, q_re_ff};
            opb = HZ_U;
         end
         carpid_pkg::MUL_DIFF_HZ: begin
            opa = diff_ff;
            opb = HZ_U;
         end
         carpid_pkg::MUL_RP_RE: begin
            opa = {gains.rate_p[31], gains.rate_p};
            opb = {re_ff[31], re_ff};
         end
         carpid_pkg::MUL_RD_DR: begin
            opa = {gains.rate_d[31], gains.rate_d};
            opb = {dr_ff[31], dr_ff};
         end
         carpid_pkg::MUL_AD_RATE: begin
            opa = {gains.angle_d[31], gains.angle_d};
            opb = {rate_ff[31], rate_ff};
         end
         carpid_pkg::MUL_RI_RSUM: begin
            opa = {gains.rate_i[31], gains.rate_i};
            opb = {rsum_ff[31], rsum_ff};
         end
         carpid_pkg::MUL_AI_ASUM: begin
            opa = {gains.angle_i[31], gains.angle_i};
            opb = {asum_ff[31], asum_ff};
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   assign full    = opa * opb;
   assign prod_in = full[carpid_pkg::PROD_W-1:0];

   // Gain product floored to Q16.16.
   assign term = prod_ff[carpid_pkg::PROD_W-1:16];
   assign tr   = sat_to_32({{16{term[carpid_pkg::TERM_W-1]}}, term});

   // Remainders of the reciprocal quotients; one step of correction suffices.
   assign rem_ae = {1'b0, abs_ae_ff} - prod_ff[32:0];
   assign rem_re = {1'b0, abs_re_ff} - prod_ff[32:0];
   assign up_ae  = (rem_ae >= HZ_U);
   assign up_re  = (rem_re >= HZ_U);

   // Next-value logic of the working registers.
   always_comb begin
      rate_in   = rate_ff;
      ae_in     = ae_ff;
      re_in     = re_ff;
      q_ae_in   = q_ae_ff;
      q_re_in   = q_re_ff;
      sq_ae_in  = sq_ae_ff;
      sq_re_in  = sq_re_ff;
      dr_in     = dr_ff;
      asum_in   = asum_ff;
      rsum_in   = rsum_ff;
      last_in   = last_ff;
      acc_in    = acc_ff;
      out_in    = out_ff;
      // Magnitudes and the error difference follow their sources in the next cycle.
      abs_ae_in = ae_ff[31] ? (~ae_ff + 32'd1) : ae_ff;
      abs_re_in = re_ff[31] ? (~re_ff + 32'd1) : re_ff;
      diff_in   = {re_ff[31], re_ff} - {last_ff[31], last_ff};

      if (cmd.ld_in) begin
         rate_in = measured_rate;
         ae_in   = sat_to_32({{32{target_angle[31]}}, target_angle}
                             - {{32{measured_angle[31]}}, measured_angle});
      end
      if (cmd.wr_re) begin
         re_in = sat_to_32({{32{tr[31]}}, tr} - {{32{rate_ff[31]}}, rate_ff});
      end
      if (cmd.wr_qae) begin
         q_ae_in = prod_ff[63:32];
      end
      if (cmd.wr_qre) begin
         q_re_in = prod_ff[63:32];
      end
      // Corrected quotient with the dividend's sign, truncated toward zero.
      if (cmd.fix_ae) begin
         sq_ae_in = ae_ff[31] ? (~{1'b0, q_ae_ff} + {32'd0, !up_ae})
                              : ({1'b0, q_ae_ff} + {32'd0, up_ae});
      end
      if (cmd.fix_re) begin
         sq_re_in = re_ff[31] ? (~{1'b0, q_re_ff} + {32'd0, !up_re})
                              : ({1'b0, q_re_ff} + {32'd0, up_re});
      end
      if (cmd.wr_dr) begin
         dr_in = sat_to_32(prod_ff);
      end
      if (cmd.upd_sums) begin
         asum_in = clamp_sum(asum_ff, sq_ae_ff, gains.limit);
         rsum_in = clamp_sum(rsum_ff, sq_re_ff, gains.limit);
      end
      if (cmd.acc_clr) begin
         acc_in = {{3{term[carpid_pkg::TERM_W-1]}}, term};
      end else if (cmd.acc_add) begin
         acc_in = acc_ff + {{3{term[carpid_pkg::TERM_W-1]}}, term};
      end
      if (cmd.upd_last) begin
         last_in = re_ff;
      end
      if (cmd.wr_out) begin
         out_in = sat_to_32({{13{acc_ff[carpid_pkg::ACC_W-1]}}, acc_ff});
      end
   end

   // Controller state carried from tick to tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         asum_ff <= '0;
         rsum_ff <= '0;
         last_ff <= '0;
      end else begin
         asum_ff <= asum_in;
         rsum_ff <= rsum_in;
         last_ff <= last_in;
      end
   end

   // Per-tick working values.
   always_ff @(posedge clock) begin
      rate_ff   <= rate_in;
      ae_ff     <= ae_in;
      abs_ae_ff <= abs_ae_in;
      re_ff     <= re_in;
      abs_re_ff <= abs_re_in;
      diff_ff   <= diff_in;
      q_ae_ff   <= q_ae_in;
      q_re_ff   <= q_re_in;
      sq_ae_ff  <= sq_ae_in;
      sq_re_ff  <= sq_re_in;
      dr_ff     <= dr_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
   end

   assign drive_value = out_ff;

`ifndef NO_ASSERTIONS
   a_rem_ae_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fix_ae |-> (rem_ae < HZ_TWICE_U))
      else $error("angle error quotient estimate off by more than one");

   a_rem_re_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fix_re |-> (rem_re < HZ_TWICE_U))
      else $error("rate error quotient estimate off by more than one");

   a_sums_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.upd_sums |=>
         ($signed({rsum_ff[31], rsum_ff}) <= $signed({2'b00, gains.limit}))
         && ($signed({rsum_ff[31], rsum_ff}) >= -$signed({2'b00, gains.limit}))
         && ($signed({asum_ff[31], asum_ff}) <= $signed({2'b00, gains.limit}))
         && ($signed({asum_ff[31], asum_ff}) >= -$signed({2'b00, gains.limit})))
      else $error("integral left its clamp range");
`endif

endmodule

// ===== tb/sv/cascaded_angle_rate_pid_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the cascaded angle/rate PID controller, driven through its ports.
module cascaded_angle_rate_pid_tb;

   localparam int          LOOP_HZ         = 200;
   localparam int unsigned NO_SUCH_REG     = 7;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          DRAIN_CYCLES    = 40;
   localparam int          RANDOM_PHASES   = 7;
   localparam int          TICKS_PER_PHASE = 200;
   localparam int          MAX_REPORTS     = 10;
   localparam longint      S32_MAX         = 64'sd2147483647;
   localparam longint      S32_MIN         = -64'sd2147483648;

   // Scoreboard: keeps its own copy of the gains and loop state and predicts each drive value.
   class drive_scoreboard;
      longint angle_p, angle_i, angle_d, rate_p, rate_i, rate_d, limit;
      longint last_rate_err, angle_err_sum, rate_err_sum;
      logic signed [31:0] expected_drive_q[$];
      int failures;
      int ticks;
      int drives;

      function new();
         angle_p       = longint'($signed(carpid_pkg::ANGLE_P_RST));
         angle_i       = longint'($signed(carpid_pkg::ANGLE_I_RST));
         angle_d       = longint'($signed(carpid_pkg::ANGLE_D_RST));
         rate_p        = longint'($signed(carpid_pkg::RATE_P_RST));
         rate_i        = longint'($signed(carpid_pkg::RATE_I_RST));
         rate_d        = longint'($signed(carpid_pkg::RATE_D_RST));
         limit         = longint'(carpid_pkg::LIMIT_RST);
         last_rate_err = 0;
         angle_err_sum = 0;
         rate_err_sum  = 0;
         failures      = 0;
         ticks         = 0;
         drives        = 0;
      endfunction

      function longint sat32(longint x);
         if (x > S32_MAX) return S32_MAX;
         if (x < S32_MIN) return S32_MIN;
         return x;
      endfunction

      // Exact product, then Q16.16 rescale rounding toward minus infinity.
      function longint mul_q16(longint g, longint x);
         return (g * x) >>> 16;
      endfunction

      function longint clamp_sum(longint s);
         if (s > limit) return limit;
         if (s < -limit) return -limit;
         return s;
      endfunction

      // A write lands in the model at the same edge it lands in the block.
      function void apply_register(int unsigned index, logic [31:0] value);
         case (index)
            carpid_pkg::REG_ANGLE_P: angle_p = longint'($signed(value));
            carpid_pkg::REG_ANGLE_I: angle_i = longint'($signed(value));
            carpid_pkg::REG_ANGLE_D: angle_d = longint'($signed(value));
            carpid_pkg::REG_RATE_P:  rate_p  = longint'($signed(value));
            carpid_pkg::REG_RATE_I:  rate_i  = longint'($signed(value));
            carpid_pkg::REG_RATE_D:  rate_d  = longint'($signed(value));
            carpid_pkg::REG_LIMIT:   limit   = longint'(value[carpid_pkg::LIM_W-1:0]);
            default: ;
         endcase
      endfunction

      // One control tick: angle loop feeds the rate target, then the five terms are summed.
      function void note_tick(logic signed [31:0] tgt, logic signed [31:0] ang,
                              logic signed [31:0] rate);
         longint hz, ae, tr, re, dr, total, meas_rate;
         logic [63:0] clipped;
         hz        = (LOOP_HZ < 1) ? 1 : LOOP_HZ;
         meas_rate = rate;
         ae = sat32(longint'(tgt) - longint'(ang));
         tr = sat32(mul_q16(angle_p, ae));
         re = sat32(tr - meas_rate);
         // Integrals accumulate error per second, division truncates toward zero.
         rate_err_sum  = clamp_sum(rate_err_sum + re / hz);
         angle_err_sum = clamp_sum(angle_err_sum + ae / hz);
         dr = sat32((re - last_rate_err) * hz);
         total = mul_q16(rate_p, re) + mul_q16(rate_i, rate_err_sum)
               + mul_q16(rate_d, dr) + mul_q16(angle_i, angle_err_sum)
               + mul_q16(angle_d, meas_rate);
         last_rate_err = re;
         clipped = sat32(total);
         expected_drive_q.push_back(clipped[31:0]);
         ticks++;
      endfunction

      function void check_drive(logic signed [31:0] got);
         logic signed [31:0] want;
         drives++;
         if (expected_drive_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: drive_value %0d arrived with no tick outstanding", $time, got);
            return;
         end
         want = expected_drive_q.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: drive_value mismatch on beat %0d: expected %0d, got %0d",
                        $time, drives, want, got);
         end
      endfunction

      function int pending();
         return expected_drive_q.size();
      endfunction

      function void finish_check();
         if (expected_drive_q.size() != 0) begin
            failures += expected_drive_q.size();
            $display("%0d drive values never arrived", expected_drive_q.size());
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [carpid_pkg::ADDR_W-1:0]     paddr;
   logic [carpid_pkg::DATA_W-1:0]     pwdata;
   logic [carpid_pkg::DATA_W-1:0]     prdata;
   logic                              pready;

   bit                 req_idle;
   bit                 rsp_idle;
   int                 quiet_cycles = 0;
   int                 settings_used = 0;
   drive_scoreboard    board;
   logic signed [31:0] track_tgt;
   logic signed [31:0] track_ang;
   logic signed [31:0] track_rate;

   carpid_req_if req_ch();
   carpid_rsp_if rsp_ch();

   cascaded_angle_rate_pid #(
      .LOOP_RATE_HZ (LOOP_HZ)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #4 clock = ~clock;

   // Mostly small signed values, some full-range noise and some extremes.
   function automatic logic [31:0] pick_value(int unsigned mag_bits);
      int unsigned sel;
      logic [31:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         case ($urandom_range(0, 4))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'h0000_0000;
            3: v = 32'h0000_0001;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else if (sel < 30) begin
         v = $urandom;
      end else begin
         v = $urandom & ((32'd1 << mag_bits) - 32'd1);
         if ($urandom_range(0, 1) == 1) v = -v;
      end
      return v;
   endfunction

   // Send one tick beat after a random gap; returns at the edge it is accepted.
   task automatic send_tick(input logic [31:0] tgt, input logic [31:0] ang,
                            input logic [31:0] rate);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.target_angle   <= tgt;
      req_ch.measured_angle <= ang;
      req_ch.measured_rate  <= rate;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_tick(tgt, ang, rate);
   endtask

   // Stop sending and wait until every outstanding drive value has been taken.
   task automatic drain_ticks();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready.
   task automatic write_register(input int unsigned index, input logic [31:0] value);
      logic [31:0] byte_addr;
      byte_addr = index * 4;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= byte_addr[carpid_pkg::ADDR_W-1:0];
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.apply_register(index, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_gains(input logic [31:0] ap, input logic [31:0] ai,
                              input logic [31:0] ad, input logic [31:0] rp,
                              input logic [31:0] ri, input logic [31:0] rd,
                              input logic [31:0] lim);
      write_register(carpid_pkg::REG_ANGLE_P, ap);
      write_register(carpid_pkg::REG_ANGLE_I, ai);
      write_register(carpid_pkg::REG_ANGLE_D, ad);
      write_register(carpid_pkg::REG_RATE_P, rp);
      write_register(carpid_pkg::REG_RATE_I, ri);
      write_register(carpid_pkg::REG_RATE_D, rd);
      write_register(carpid_pkg::REG_LIMIT, lim);
      settings_used++;
   endtask

   task automatic random_gains();
      logic [31:0] lim;
      case ($urandom_range(0, 3))
         0: lim = 32'h0000_0000;
         1: lim = 32'h7FFF_FFFF;
         2: lim = $urandom_range(0, 32'h0004_0000);
         default: lim = $urandom;
      endcase
      write_gains(pick_value(20), pick_value(16), pick_value(18), pick_value(20),
                  pick_value(18), pick_value(12), lim);
   endtask

   // Result side: random stall after each beat, checked against the scoreboard.
   initial begin : result_sink
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_ch.ready <= 1'b0;
            hold = 0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_drive(rsp_ch.drive_value);
            hold = rsp_idle ? $urandom_range(0, 14) : 0;
            rsp_ch.ready <= (hold == 0);
         end else if (hold > 1) begin
            hold = hold - 1;
         end else begin
            hold = 0;
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when no beat and no register access has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles, giving up", $time, quiet_cycles);
         $display("cascaded_angle_rate_pid_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus.
   initial begin
      int step;
      int unsigned mag;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.target_angle   = '0;
      req_ch.measured_angle = '0;
      req_ch.measured_rate  = '0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_idle              = 1'b0;
      rsp_idle              = 1'b0;
      track_tgt             = '0;
      track_ang             = '0;
      track_rate            = '0;
      board                 = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset gains: zero tick, a unit step, and saturated angle error and rate.
      settings_used++;
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_tick(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      send_tick(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);

      // Largest positive gains and limit: the output sum saturates.
      drain_ticks();
      write_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_tick(32'h0001_0000, 32'h0000_0000, 32'h0000_0064);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

      // Most negative gains with a zero limit: both integrals are held at zero.
      drain_ticks();
      write_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
      send_tick(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_tick(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_tick(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

      // Unit angle-P and rate-D gains only, plus a write to an unmapped register that must be ignored.
      drain_ticks();
      write_gains(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      write_register(NO_SUCH_REG, $urandom);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      send_tick(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);

      // Random phases: mostly tracking sequences so the integrals build up, some noise.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_ticks();
         random_gains();
         mag = $urandom_range(14, 26);
         track_ang  = pick_value(mag);
         track_rate = pick_value(mag);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               req_idle = ($urandom_range(0, 3) != 0);
               rsp_idle = ($urandom_range(0, 3) != 0);
            end
            // Let the block run dry once per phase before carrying on.
            if (n == TICKS_PER_PHASE / 2) drain_ticks();
            if (n % 25 == 0) track_tgt = pick_value(mag);
            if ($urandom_range(0, 9) < 7) begin
               step = $urandom_range(0, 4095);
               track_ang  = track_ang + (step - 2048);
               step = $urandom_range(0, 16383);
               track_rate = track_rate + (step - 8192);
               send_tick(track_tgt, track_ang, track_rate);
            end else begin
               send_tick(pick_value(mag), pick_value(mag), pick_value(mag + 2));
            end
         end
      end

      // Wind down: every tick answered, then a quiet stretch for stray beats.
      drain_ticks();
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.finish_check();
      $display("Checked %0d ticks and %0d drive values over %0d gain settings,",
               board.ticks, board.drives, settings_used);
      $display("covering saturation, zero integral limit and an ignored register write.");
      if (board.failures == 0) begin
         $display("cascaded_angle_rate_pid_tb: PASS");
      end else begin
         $display("cascaded_angle_rate_pid_tb: FAIL");
      end
      $finish;
   end

endmodule
